### rtl/pdrb_pkg.sv
// Shared types, codes and constants of the packet descriptor ring buffer.
package pdrb_pkg;

    // Default sizes handed to the top level
    localparam int DEF_DESC_DEPTH  = 256;
    localparam int DEF_BUF_BYTES   = 65536;
    localparam int DEF_SLACK_BYTES = 2048;

    // Fixed field widths of the channels
    localparam int ACTION_W = 2;
    localparam int HDR_W    = 64;
    localparam int LEN_W    = 12;
    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 17;

    typedef enum logic [ACTION_W-1:0] {
        ACT_HEADER = 2'd0,
        ACT_DATA   = 2'd1,
        ACT_POP    = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    // What the pending result carries beyond the accepted flag
    typedef enum logic [1:0] {
        RES_NONE = 2'd0,
        RES_DESC = 2'd1,
        RES_BYTE = 2'd2
    } t_res;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RESP = 1'b1
    } t_state;

    typedef struct packed {
        logic exec;
        logic load_out;
    } t_cmd;

endpackage

### rtl/pdrb_if.sv
// Valid/ready channel interfaces for input items and result items.
interface pdrb_in_if import pdrb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [HDR_W-1:0]    header_word;
    logic [LEN_W-1:0]    packet_length;
    logic [BYTE_W-1:0]   data_value;
    logic [ADDR_W-1:0]   byte_address;

    modport source (
        output valid, action, header_word, packet_length, data_value, byte_address,
        input  ready
    );
    modport sink (
        input  valid, action, header_word, packet_length, data_value, byte_address,
        output ready
    );
endinterface

interface pdrb_out_if import pdrb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              accepted;
    logic [HDR_W-1:0]  out_header_word;
    logic [LEN_W-1:0]  out_length;
    logic [ADDR_W-1:0] start_offset;
    logic [BYTE_W-1:0] out_byte;

    modport source (
        output valid, accepted, out_header_word, out_length, start_offset, out_byte,
        input  ready
    );
    modport sink (
        input  valid, accepted, out_header_word, out_length, start_offset, out_byte,
        output ready
    );
endinterface

### rtl/pdrb_ram.sv
// Generic single-port RAM with registered read data.
module pdrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pdrb_ctrl.sv
// Controller: sequences accept, memory access and result hand-over.
module pdrb_ctrl import pdrb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_cmd   w_cmd;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // Outputs and commands
    always_comb begin
        w_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                w_cmd.exec = i_in_valid;
            end
            S_RESP: begin
                w_cmd.load_out = !r_out_valid || i_out_ready;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_accept_to_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_RESP))
        else $error("accepted item did not move to the response state");
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> r_out_valid)
        else $error("loaded result not presented");
    a_resp_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && !w_cmd.load_out) |=> (r_state == S_RESP))
        else $error("result dropped while the output register was occupied");
`endif

endmodule

### rtl/pdrb_dp.sv
// Datapath: ring pointers, write offset, descriptor ring, byte store, result register.
module pdrb_dp import pdrb_pkg::*; #(
    parameter int DESC_DEPTH  = DEF_DESC_DEPTH,
    parameter int BUF_BYTES   = DEF_BUF_BYTES,
    parameter int SLACK_BYTES = DEF_SLACK_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [HDR_W-1:0]    i_header_word,
    input  logic [LEN_W-1:0]    i_packet_length,
    input  logic [BYTE_W-1:0]   i_data_value,
    input  logic [ADDR_W-1:0]   i_byte_address,
    output logic                o_accepted,
    output logic [HDR_W-1:0]    o_header_word,
    output logic [LEN_W-1:0]    o_length,
    output logic [ADDR_W-1:0]   o_start_offset,
    output logic [BYTE_W-1:0]   o_byte
);

    localparam int STORE_BYTES = BUF_BYTES + SLACK_BYTES;
    localparam int OW          = $clog2(STORE_BYTES);
    localparam int IW          = $clog2(DESC_DEPTH);
    localparam int DW          = HDR_W + LEN_W + OW;

    // Pointer and fill state
    logic [OW-1:0]    r_wo, n_wo;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic             r_drop, n_drop;
    logic [IW-1:0]    r_push, n_push;
    logic [IW-1:0]    r_pop, n_pop;
    logic [IW-1:0]    r_used, n_used;

    // Pending result
    logic r_acc, n_acc;
    t_res r_kind, n_kind;

    // Result register
    logic              r_o_acc;
    logic [HDR_W-1:0]  r_o_hdr;
    logic [LEN_W-1:0]  r_o_len;
    logic [ADDR_W-1:0] r_o_off;
    logic [BYTE_W-1:0] r_o_byte;

    // Memory controls
    logic              w_desc_en, w_desc_we;
    logic [IW-1:0]     w_desc_addr;
    logic [DW-1:0]     w_desc_wdata, w_desc_rdata;
    logic              w_st_en, w_st_we;
    logic [OW-1:0]     w_st_addr;
    logic [BYTE_W-1:0] w_st_rdata;

    t_action           w_act;
    logic [OW-1:0]     w_wo_base;
    logic [OW-1:0]     w_wo_inc;
    logic [IW-1:0]     w_push_inc;
    logic [IW-1:0]     w_pop_inc;
    logic [31:0]       w_rd_addr;
    logic [31:0]       w_off_ext;

    assign w_act      = t_action'(i_action);
    assign w_wo_base  = (r_wo >= OW'(BUF_BYTES)) ? '0 : r_wo;
    assign w_wo_inc   = r_wo + OW'(1);
    assign w_push_inc = (r_push == IW'(DESC_DEPTH - 1)) ? '0 : r_push + IW'(1);
    assign w_pop_inc  = (r_pop == IW'(DESC_DEPTH - 1)) ? '0 : r_pop + IW'(1);
    assign w_rd_addr  = 32'(i_byte_address);
    assign w_off_ext  = 32'(w_desc_rdata[OW-1:0]);

    always_comb begin
        n_wo         = r_wo;
        n_rem        = r_rem;
        n_drop       = r_drop;
        n_push       = r_push;
        n_pop        = r_pop;
        n_used       = r_used;
        n_acc        = r_acc;
        n_kind       = r_kind;
        w_desc_en    = 1'b0;
        w_desc_we    = 1'b0;
        w_desc_addr  = r_push;
        w_desc_wdata = {i_header_word, i_packet_length, w_wo_base};
        w_st_en      = 1'b0;
        w_st_we      = 1'b0;
        w_st_addr    = r_wo;
        if (i_cmd.exec) begin
            n_acc  = 1'b0;
            n_kind = RES_NONE;
            unique case (w_act)
                ACT_HEADER: begin
                    // Abandon any unfinished packet, wrap, then commit or refuse
                    n_wo  = w_wo_base;
                    n_rem = i_packet_length;
                    if (r_used != IW'(DESC_DEPTH - 1)
                            && 32'(i_packet_length) <= 32'(SLACK_BYTES)) begin
                        w_desc_en = 1'b1;
                        w_desc_we = 1'b1;
                        n_push    = w_push_inc;
                        n_used    = r_used + IW'(1);
                        n_drop    = 1'b0;
                        n_acc     = 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                end
                ACT_DATA: begin
                    if (r_rem != '0) begin
                        n_rem = r_rem - LEN_W'(1);
                        if (!r_drop) begin
                            w_st_en = 1'b1;
                            w_st_we = 1'b1;
                            n_acc   = 1'b1;
                            n_wo    = (r_rem == LEN_W'(1) && w_wo_inc >= OW'(BUF_BYTES))
                                      ? '0 : w_wo_inc;
                        end
                    end
                end
                ACT_POP: begin
                    if (r_used != '0) begin
                        w_desc_en   = 1'b1;
                        w_desc_addr = r_pop;
                        n_pop       = w_pop_inc;
                        n_used      = r_used - IW'(1);
                        n_acc       = 1'b1;
                        n_kind      = RES_DESC;
                    end
                end
                ACT_READ: begin
                    if (w_rd_addr < 32'(STORE_BYTES)) begin
                        w_st_en   = 1'b1;
                        w_st_addr = w_rd_addr[OW-1:0];
                        n_acc     = 1'b1;
                        n_kind    = RES_BYTE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wo   <= '0;
            r_rem  <= '0;
            r_drop <= 1'b0;
            r_push <= '0;
            r_pop  <= '0;
            r_used <= '0;
        end else begin
            r_wo   <= n_wo;
            r_rem  <= n_rem;
            r_drop <= n_drop;
            r_push <= n_push;
            r_pop  <= n_pop;
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_kind <= n_kind;
        if (i_cmd.load_out) begin
            r_o_acc  <= r_acc;
            r_o_hdr  <= (r_kind == RES_DESC) ? w_desc_rdata[DW-1 -: HDR_W] : '0;
            r_o_len  <= (r_kind == RES_DESC) ? w_desc_rdata[OW +: LEN_W] : '0;
            r_o_off  <= (r_kind == RES_DESC) ? w_off_ext[ADDR_W-1:0] : '0;
            r_o_byte <= (r_kind == RES_BYTE) ? w_st_rdata : '0;
        end
    end

    pdrb_ram #(
        .WIDTH (DW),
        .DEPTH (DESC_DEPTH)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_en    (w_desc_en),
        .i_we    (w_desc_we),
        .i_addr  (w_desc_addr),
        .i_wdata (w_desc_wdata),
        .o_rdata (w_desc_rdata)
    );

    pdrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_en    (w_st_en),
        .i_we    (w_st_we),
        .i_addr  (w_st_addr),
        .i_wdata (i_data_value),
        .o_rdata (w_st_rdata)
    );

    assign o_accepted     = r_o_acc;
    assign o_header_word  = r_o_hdr;
    assign o_length       = r_o_len;
    assign o_start_offset = r_o_off;
    assign o_byte         = r_o_byte;

`ifndef NO_ASSERTIONS
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= IW'(DESC_DEPTH - 1))
        else $error("descriptor fill beyond ring capacity");
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used == '0) |-> (r_push == r_pop))
        else $error("empty ring with diverging pointers");
    a_no_store_on_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_act == ACT_DATA && r_drop) |-> !w_st_we)
        else $error("byte of a refused packet written to the store");
    a_wo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_wo) < 32'(STORE_BYTES))
        else $error("write offset ran past the byte store");
`endif

endmodule

### rtl/packet_descriptor_ring_buffer_unit.sv
// Top level of the packet descriptor ring buffer: controller plus datapath.
// An accepted item's memory access is registered, then its result is loaded into the
// output register, which waits while the previous result there has not been taken.
// Flow: one item in flight; after an accept, no new item is taken until its result is
// loaded, and a new item is taken while a result waits in the output register.
// Reset (synchronous, active low) clears pointers, fill count, offset and flags;
// the memories are not cleared and no clearing pass runs.
module packet_descriptor_ring_buffer_unit import pdrb_pkg::*; #(
    parameter int DESC_DEPTH  = DEF_DESC_DEPTH,
    parameter int BUF_BYTES   = DEF_BUF_BYTES,
    parameter int SLACK_BYTES = DEF_SLACK_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pdrb_in_if.sink    i_in,
    pdrb_out_if.source o_out
);

    t_cmd w_cmd;

    // Controller: one item in flight, result handed over through the output register
    pdrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    // Datapath: act on the transfer, access memory, hold the result until taken
    pdrb_dp #(
        .DESC_DEPTH  (DESC_DEPTH),
        .BUF_BYTES   (BUF_BYTES),
        .SLACK_BYTES (SLACK_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_action        (i_in.action),
        .i_header_word   (i_in.header_word),
        .i_packet_length (i_in.packet_length),
        .i_data_value    (i_in.data_value),
        .i_byte_address  (i_in.byte_address),
        .o_accepted      (o_out.accepted),
        .o_header_word   (o_out.out_header_word),
        .o_length        (o_out.out_length),
        .o_start_offset  (o_out.start_offset),
        .o_byte          (o_out.out_byte)
    );

endmodule
